// ----- design/dmt_pkg.sv -----
// ----------------------------------------------------------------------------
// dmt_pkg: shared types and constants of the DPSK modem transmitter
// Holds the ring handshake structs, carrier constants and the sine table.
// ----------------------------------------------------------------------------
package dmt_pkg;

    // Configuration register indexes.
    localparam logic REG_UNSCR_END = 1'b0;
    localparam logic REG_SCR_END   = 1'b1;

    // Reset values of the handshake thresholds, in samples.
    localparam logic [15:0] UNSCR_END_RST = 16'd7200;
    localparam logic [15:0] SCR_END_RST   = 16'd15200;

    // Carrier phase counts twentieths of a turn.
    localparam logic [5:0] PHASE_MOD    = 6'd20;
    localparam logic [5:0] CARRIER_STEP = 6'd6;

    // Symbol clock in thirds of a sample: 40/3 samples per symbol.
    localparam logic signed [6:0] SYMBOL_THIRDS = 7'sd40;
    localparam logic signed [6:0] SAMPLE_THIRDS = 7'sd3;

    // Scrambler taps and the long run of ones that forces an inversion.
    localparam int unsigned SCR_TAP_A = 13;
    localparam int unsigned SCR_TAP_B = 16;
    localparam logic [6:0]  RUN_LAST  = 7'd63;

    // Async frame: start bit, eight data bits, stop bit.
    localparam logic [3:0] FRAME_BITS = 4'd10;

    // Ring status seen by the symbol logic.
    typedef struct packed {
        logic       nonempty;
        logic       full;
        logic [7:0] head_byte;
    } ring_stat_t;

    // Requests from the item path into the ring.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       pop;
    } ring_req_t;

    // Phase advance for a dibit, in twentieths of a turn.
    function automatic logic [4:0] phase_step(input logic a, input logic b);
        logic [4:0] step;
        case ({a, b})
            2'b00:   step = 5'd5;
            2'b01:   step = 5'd0;
            2'b11:   step = 5'd15;
            default: step = 5'd10;
        endcase
        return step;
    endfunction

    // Truncated sine of amplitude 10000 at twentieths of a turn.
    function automatic logic signed [14:0] sine_lookup(input logic [4:0] idx);
        logic signed [14:0] s;
        case (idx)
            5'd0:    s = 15'sd0;
            5'd1:    s = 15'sd3090;
            5'd2:    s = 15'sd5877;
            5'd3:    s = 15'sd8090;
            5'd4:    s = 15'sd9510;
            5'd5:    s = 15'sd10000;
            5'd6:    s = 15'sd9510;
            5'd7:    s = 15'sd8090;
            5'd8:    s = 15'sd5877;
            5'd9:    s = 15'sd3090;
            5'd10:   s = 15'sd0;
            5'd11:   s = -15'sd3090;
            5'd12:   s = -15'sd5877;
            5'd13:   s = -15'sd8090;
            5'd14:   s = -15'sd9510;
            5'd15:   s = -15'sd10000;
            5'd16:   s = -15'sd9510;
            5'd17:   s = -15'sd8090;
            5'd18:   s = -15'sd5877;
            5'd19:   s = -15'sd3090;
            default: s = 15'sd0;
        endcase
        return s;
    endfunction

endpackage

// ----- design/dmt_ring.sv -----
// ----------------------------------------------------------------------------
// dmt_ring: transmit byte ring with a prefetched head byte
// One write port and one registered read port; the head byte is held in a
// register so that the symbol logic can take it without waiting.
// ----------------------------------------------------------------------------
module dmt_ring
    import dmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ring_req_t  req,
    output ring_stat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

    logic [7:0]       ring_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             fetch_pending_reg, fetch_pending_next;
    logic [7:0]       pf_data_reg;
    logic [7:0]       rd_data_reg;
    logic             empty;
    logic             full;
    logic             push_do;
    logic             pop_do;
    logic             rd_en;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    // Increment with wrap at the ring depth.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] n;
        n = {1'b0, p} + (PTR_W + 1)'(1);
        return (n >= DEPTH_EXT) ? '0 : n[PTR_W-1:0];
    endfunction

    // Occupancy and request qualification.
    always_comb
    begin
        head_inc = ring_next(head_reg);
        tail_inc = ring_next(tail_reg);
        empty    = (head_reg == tail_reg);
        full     = (tail_inc == head_reg);
        push_do  = req.push && !full;
        pop_do   = req.pop && !empty;
        // Fetch the following byte after a pop, if one is queued.
        rd_en    = pop_do && (head_inc != tail_reg);
    end

    // Pointer and fetch state updates.
    always_comb
    begin
        head_next          = pop_do ? head_inc : head_reg;
        tail_next          = push_do ? tail_inc : tail_reg;
        fetch_pending_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg          <= '0;
            tail_reg          <= '0;
            fetch_pending_reg <= 1'b0;
        end
        else
        begin
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            fetch_pending_reg <= fetch_pending_next;
        end
    end

    // Storage: write at the tail, registered read of the next head.
    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            ring_mem[tail_reg] <= req.push_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[head_inc];
        end
    end

    // Head byte holder: bypass a write into an empty ring, else take fetches.
    always_ff @(posedge clk)
    begin
        if (push_do && empty)
        begin
            pf_data_reg <= req.push_byte;
        end
        else if (fetch_pending_reg)
        begin
            pf_data_reg <= rd_data_reg;
        end
    end

    assign stat.nonempty  = !empty;
    assign stat.full      = full;
    assign stat.head_byte = fetch_pending_reg ? rd_data_reg : pf_data_reg;

endmodule

// ----- design/dmt_core.sv -----
// ----------------------------------------------------------------------------
// dmt_core: symbol timing, framing, scrambler and carrier of the transmitter
// Computes one line sample per tick and advances the modulator state.
// ----------------------------------------------------------------------------
module dmt_core
    import dmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic [15:0]        unscr_end,
    input  logic [15:0]        scr_end,
    input  ring_stat_t         ring_stat,
    output logic               pop,
    output logic signed [14:0] sample
);

    typedef struct packed {
        logic [16:0] sreg;
        logic [6:0]  run;
        logic        out;
    } scr_t;

    logic [9:0]         frame_reg, frame_next;
    logic [3:0]         left_reg, left_next;
    logic [16:0]        scr_reg, scr_next;
    logic [6:0]         run_reg, run_next;
    logic [4:0]         phase_reg, phase_next;
    logic signed [6:0]  sym_reg, sym_next;
    logic [15:0]        count_reg, count_next;

    logic               due;
    logic               mode_plain;
    logic               mode_marks;
    logic [9:0]         frame_a, frame_b;
    logic [3:0]         left_a, left_b;
    logic               line_a, line_b;
    logic               pop_a, pop_b;
    scr_t               scr_a, scr_b;
    logic               dibit_a, dibit_b;
    logic [5:0]         phase_sum;
    logic [4:0]         phase_sym;
    logic [5:0]         carrier_sum;
    logic [4:0]         phase_adv;

    // One scrambler bit with the forced inversion after 63 ones.
    function automatic scr_t scramble(input logic b, input logic [16:0] s,
                                      input logic [6:0] run);
        scr_t r;
        r.out  = b ^ s[SCR_TAP_A] ^ s[SCR_TAP_B];
        r.run  = 7'd0;
        if (r.out)
        begin
            if (run == RUN_LAST)
            begin
                r.out = 1'b0;
            end
            else
            begin
                r.run = run + 7'd1;
            end
        end
        r.sreg = {s[15:0], r.out};
        return r;
    endfunction

    // Symbol due flag and handshake phase selection.
    always_comb
    begin
        due        = (sym_reg <= 7'sd0);
        mode_plain = (count_reg < unscr_end);
        mode_marks = !mode_plain && (count_reg < scr_end);
    end

    // First line bit of the dibit: from the frame, a new byte, or an idle mark.
    always_comb
    begin
        frame_a = frame_reg;
        left_a  = left_reg;
        line_a  = 1'b1;
        pop_a   = 1'b0;
        if (left_reg == 4'd0)
        begin
            if (ring_stat.nonempty)
            begin
                frame_a = {1'b1, ring_stat.head_byte, 1'b0};
                left_a  = FRAME_BITS - 4'd1;
                line_a  = 1'b0;
                pop_a   = 1'b1;
            end
        end
        else
        begin
            line_a = frame_reg[FRAME_BITS - left_reg];
            left_a = left_reg - 4'd1;
        end
    end

    // Second line bit, continuing from the state the first one left.
    always_comb
    begin
        frame_b = frame_a;
        left_b  = left_a;
        line_b  = 1'b1;
        pop_b   = 1'b0;
        if (left_a == 4'd0)
        begin
            if (ring_stat.nonempty && !pop_a)
            begin
                frame_b = {1'b1, ring_stat.head_byte, 1'b0};
                left_b  = FRAME_BITS - 4'd1;
                line_b  = 1'b0;
                pop_b   = 1'b1;
            end
        end
        else
        begin
            line_b = frame_a[FRAME_BITS - left_a];
            left_b = left_a - 4'd1;
        end
    end

    // Scrambler: plain ones first, marks during the scrambled handshake, line bits afterward.
    always_comb
    begin
        scr_a = scramble(mode_marks ? 1'b1 : line_a, scr_reg, run_reg);
        scr_b = scramble(mode_marks ? 1'b1 : line_b, scr_a.sreg, scr_a.run);
        if (mode_plain)
        begin
            dibit_a = 1'b1;
            dibit_b = 1'b1;
        end
        else
        begin
            dibit_a = scr_a.out;
            dibit_b = scr_b.out;
        end
    end

    // Carrier phase: symbol step, sample lookup, then the per-sample advance.
    always_comb
    begin
        phase_sum = {1'b0, phase_reg} + {1'b0, phase_step(dibit_a, dibit_b)};
        if (!due)
        begin
            phase_sym = phase_reg;
        end
        else if (phase_sum >= PHASE_MOD)
        begin
            phase_sym = 5'(phase_sum - PHASE_MOD);
        end
        else
        begin
            phase_sym = phase_sum[4:0];
        end
        sample      = sine_lookup(phase_sym);
        carrier_sum = {1'b0, phase_sym} + CARRIER_STEP;
        phase_adv   = (carrier_sum >= PHASE_MOD) ? 5'(carrier_sum - PHASE_MOD)
                                                 : carrier_sum[4:0];
    end

    // Next state for one tick.
    always_comb
    begin
        frame_next = frame_reg;
        left_next  = left_reg;
        scr_next   = scr_reg;
        run_next   = run_reg;
        phase_next = phase_reg;
        sym_next   = sym_reg;
        count_next = count_reg;
        pop        = 1'b0;
        if (tick)
        begin
            if (due && !mode_plain)
            begin
                scr_next = scr_b.sreg;
                run_next = scr_b.run;
                if (!mode_marks)
                begin
                    frame_next = frame_b;
                    left_next  = left_b;
                    pop        = pop_a || pop_b;
                end
            end
            phase_next = phase_adv;
            sym_next   = sym_reg + (due ? SYMBOL_THIRDS : 7'sd0) - SAMPLE_THIRDS;
            if (count_reg != 16'hFFFF)
            begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            left_reg  <= '0;
            scr_reg   <= '0;
            run_reg   <= '0;
            phase_reg <= '0;
            sym_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            left_reg  <= left_next;
            scr_reg   <= scr_next;
            run_reg   <= run_next;
            phase_reg <= phase_next;
            sym_reg   <= sym_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/dpsk_modem_transmitter_unit.sv -----
// ----------------------------------------------------------------------------
// dpsk_modem_transmitter_unit: 1200 bit/s quarter-phase DPSK transmitter
// Byte ring, framing, scrambler and 2400 Hz carrier at 8000 samples/s.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat per item. s_tuser = 1 is a sample tick,
//   s_tuser = 0 writes s_tdata into the transmit ring.
//   The master stream returns exactly one beat per item: the line sample for
//   a tick (0 for a write) and, for a write, whether the ring took the byte.
//   A full ring (QUEUE_DEPTH-1 bytes) drops the byte and reports 0.
//   An accepted item passes an input register and one result register
//   before it shows on the master side.
//   Throughput: one item per cycle while the receiver takes results; the ring
//   read behind the head byte finishes long before the framer can ask for another byte.
//   The handshake thresholds are set through the write port; write them only
//   while no item is in flight.
//   Reset clears pointers, modulator state and the sample count and loads the
//   default thresholds. Ring contents are not cleared.
//   When the receiver stalls, the result beat holds, one more item can wait
//   in the input register, and then s_tready drops.
// ----------------------------------------------------------------------------
module dpsk_modem_transmitter_unit
    import dmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] sample, [15] byte_accepted
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [14:0] out_sample_reg;
    logic               out_acc_reg;
    logic [15:0]        unscr_end_reg;
    logic [15:0]        scr_end_reg;
    logic               advance;
    logic               take_in;
    ring_req_t          ring_req;
    ring_stat_t         ring_stat;
    logic               core_pop;
    logic signed [14:0] core_sample;

    // Pipeline control: an item advances when the result slot is free.
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        take_in        = s_tvalid && s_tready;
        in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unscr_end_reg <= UNSCR_END_RST;
            scr_end_reg   <= SCR_END_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_UNSCR_END: unscr_end_reg <= cfg_data;
                REG_SCR_END:   scr_end_reg   <= cfg_data;
                default:       scr_end_reg   <= scr_end_reg;
            endcase
        end
    end

    // Ring requests for the item in the input register.
    always_comb
    begin
        ring_req.push      = advance && !in_cmd_reg;
        ring_req.push_byte = in_byte_reg;
        ring_req.pop       = core_pop;
    end

    dmt_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .stat  (ring_stat)
    );

    dmt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (advance && in_cmd_reg),
        .unscr_end (unscr_end_reg),
        .scr_end   (scr_end_reg),
        .ring_stat (ring_stat),
        .pop       (core_pop),
        .sample    (core_sample)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= in_cmd_reg ? core_sample : 15'sd0;
            out_acc_reg    <= !in_cmd_reg && !ring_stat.full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_acc_reg, out_sample_reg};

endmodule

// ----- design/dmt_checker.sv -----
// ----------------------------------------------------------------------------
// dmt_checker: port-level checks of the DPSK modem transmitter
// Watches the two streams and flags results or stalls that cannot occur.
// ----------------------------------------------------------------------------
module dmt_checker
    import dmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result beat that the receiver refuses holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // The samples stay within the carrier amplitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd10000) &&
                     ($signed(m_tdata[14:0]) >= -15'sd10000))
    else $error("sample outside carrier amplitude");

    // An accepted byte is a write result, which carries a zero sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14:0] == 15'd0)
    else $error("byte acceptance with nonzero sample");

    // Input back-pressure only appears while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with no waiting result");

    // After an input is refused, either a result is held or the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> m_tvalid || s_tready)
    else $error("stall left no result behind");

endmodule

bind dpsk_modem_transmitter_unit dmt_checker u_dmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
